@@ design/atws_pkg.sv @@
// ----------------------------------------------------------------------------
// atws_pkg
// Shared constants and types for the alias table weighted sampler.
// ----------------------------------------------------------------------------
package atws_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int FRAC_BITS   = 24;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int WEIGHT_W    = FRAC_BITS + 1;
    localparam int COIN_W      = FRAC_BITS;
    localparam int SCALED_W    = WEIGHT_W + CNT_W;
    localparam int TBL_W       = WEIGHT_W + IDX_W;

    localparam logic [SCALED_W-1:0] ONE_FX = SCALED_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0]    N_MAX  = CNT_W'(MAX_ENTRIES);

    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [SCALED_W-1:0] t_scaled;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_BUILT = 2'd1,
        STAT_RANGE     = 2'd2
    } t_status;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

endpackage

@@ design/atws_ram.sv @@
// ----------------------------------------------------------------------------
// atws_ram
// Simple dual port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module atws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/alias_table_weighted_sampler_top.sv @@
// ----------------------------------------------------------------------------
// alias_table_weighted_sampler_top
// Weighted sampler by the alias method over RAM based weight, table and stack
// stores.
// ----------------------------------------------------------------------------
// A load transfer, while fewer than n are loaded, writes weight*n into the weight
// RAM. A sample transfer does one RAM read of threshold and alias for the bin,
// then the compare into the output register, waiting while that register is full
// and not taken. The load marked last starts the table build, during which no input
// transfer is taken: a read and a write per entry for the stack fill, a check
// and states P0 to P4 per small/large pairing, a check, a read and a write per
// leftover entry, plus one final check, as the weight and stack RAMs have one read port.
module alias_table_weighted_sampler_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [atws_pkg::CNT_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_cmd,
    input  logic [atws_pkg::WEIGHT_W-1:0]  i_weight,
    input  logic                           i_last,
    input  logic [atws_pkg::IDX_W-1:0]     i_bin,
    input  logic [atws_pkg::COIN_W-1:0]    i_coin,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [atws_pkg::IDX_W-1:0]     o_chosen_index,
    output logic [1:0]                     o_status
);
    import atws_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SAMP    = 4'd1;
    localparam logic [3:0] ST_PUSH_RD = 4'd2;
    localparam logic [3:0] ST_PUSH_WR = 4'd3;
    localparam logic [3:0] ST_CHK     = 4'd4;
    localparam logic [3:0] ST_P0      = 4'd5;
    localparam logic [3:0] ST_P1      = 4'd6;
    localparam logic [3:0] ST_P2      = 4'd7;
    localparam logic [3:0] ST_P3      = 4'd8;
    localparam logic [3:0] ST_P4      = 4'd9;
    localparam logic [3:0] ST_LL_RD   = 4'd10;
    localparam logic [3:0] ST_LL_WR   = 4'd11;
    localparam logic [3:0] ST_LS_RD   = 4'd12;
    localparam logic [3:0] ST_LS_WR   = 4'd13;

    logic [3:0] r_state, n_state;
    t_cnt       r_n, r_lc, r_i, r_st, r_lt;
    logic       r_ready_tbl;
    t_idx       r_bin, r_s, r_l;
    logic [COIN_W-1:0] r_coin;
    t_scaled    r_ws;
    logic       r_ov;
    t_idx       r_chosen;
    logic [1:0] r_status;

    logic       w_we, s_we, t_we;
    t_idx       w_wa, w_ra, s_wa, s_ra, t_wa, t_ra;
    t_scaled    w_wd, w_rd;
    t_idx       s_wd, s_rd;
    logic [TBL_W-1:0] t_wd, t_rd;

    t_scaled    push_val, pair_new;
    t_cnt       cfg_n;
    logic       out_free;
    logic       in_xfer, cfg_xfer;
    t_idx       st_top, lt_top;

    atws_ram #(.WIDTH(SCALED_W), .DEPTH(MAX_ENTRIES)) u_wram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_wa), .i_wdata(w_wd),
        .i_raddr(w_ra), .o_rdata(w_rd)
    );
    atws_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_sram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd)
    );
    atws_ram #(.WIDTH(TBL_W), .DEPTH(MAX_ENTRIES)) u_tram (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_rd)
    );

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_ready     = (r_state == ST_IDLE) && !i_cfg_valid;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign in_xfer     = i_valid && o_ready;
    assign out_free    = !r_ov || i_ready;

    // small stack grows up from 0, large stack grows down from the top
    assign st_top   = IDX_W'(r_st - CNT_W'(1));
    assign lt_top   = IDX_W'(N_MAX - r_lt);
    assign push_val = (r_i >= r_lc) ? '0 : w_rd;
    assign pair_new = w_rd + r_ws - ONE_FX;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_n = CNT_W'(1);
        end else if (i_cfg_data > N_MAX) begin
            cfg_n = N_MAX;
        end else begin
            cfg_n = i_cfg_data;
        end
    end

    always_comb begin
        w_we = 1'b0;
        w_wa = r_lc[IDX_W-1:0];
        w_wd = SCALED_W'(i_weight) * SCALED_W'(r_n);
        w_ra = r_i[IDX_W-1:0];
        s_we = 1'b0;
        s_wa = r_st[IDX_W-1:0];
        s_wd = r_i[IDX_W-1:0];
        s_ra = st_top;
        t_we = 1'b0;
        t_wa = r_s;
        t_wd = {r_ws[WEIGHT_W-1:0], r_l};
        t_ra = (r_state == ST_IDLE) ? i_bin : r_bin;
        unique case (r_state)
            ST_IDLE: begin
                w_we = in_xfer && (i_cmd == CMD_LOAD) && (r_lc < r_n);
            end
            ST_PUSH_WR: begin
                w_wa = r_i[IDX_W-1:0];
                w_wd = '0;
                w_we = (r_i >= r_lc);
                s_we = 1'b1;
                if (push_val >= ONE_FX) begin
                    s_wa = lt_top - IDX_W'(1);
                end
            end
            ST_P1: s_ra = lt_top;
            ST_P2: w_ra = r_s;
            ST_P3: w_ra = r_l;
            ST_P4: begin
                w_we = 1'b1;
                w_wa = r_l;
                w_wd = pair_new;
                t_we = 1'b1;
                s_we = (pair_new < ONE_FX);
                s_wa = st_top;
                s_wd = r_l;
            end
            ST_LL_RD: s_ra = lt_top;
            ST_LL_WR, ST_LS_WR: begin
                t_we = 1'b1;
                t_wa = s_rd;
                t_wd = {ONE_FX[WEIGHT_W-1:0], s_rd};
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_cmd == CMD_SAMPLE) begin
                        n_state = ST_SAMP;
                    end else if (i_last) begin
                        n_state = ST_PUSH_RD;
                    end
                end
            end
            ST_SAMP:    if (out_free) n_state = ST_IDLE;
            ST_PUSH_RD: n_state = ST_PUSH_WR;
            ST_PUSH_WR: n_state = (r_i + CNT_W'(1) == r_n) ? ST_CHK : ST_PUSH_RD;
            ST_CHK: begin
                priority if (r_st != '0 && r_lt != '0) n_state = ST_P0;
                else if (r_lt != '0) n_state = ST_LL_RD;
                else if (r_st != '0) n_state = ST_LS_RD;
                else n_state = ST_IDLE;
            end
            ST_P0:    n_state = ST_P1;
            ST_P1:    n_state = ST_P2;
            ST_P2:    n_state = ST_P3;
            ST_P3:    n_state = ST_P4;
            ST_P4:    n_state = ST_CHK;
            ST_LL_RD: n_state = ST_LL_WR;
            ST_LL_WR: n_state = ST_CHK;
            ST_LS_RD: n_state = ST_LS_WR;
            ST_LS_WR: n_state = ST_CHK;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_n         <= N_MAX;
            r_lc        <= '0;
            r_i         <= '0;
            r_st        <= '0;
            r_lt        <= '0;
            r_ready_tbl <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SAMP && out_free) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_i  <= '0;
                    r_st <= '0;
                    r_lt <= '0;
                    if (cfg_xfer) begin
                        r_n         <= cfg_n;
                        r_lc        <= '0;
                        r_ready_tbl <= 1'b0;
                    end else if (in_xfer && i_cmd == CMD_LOAD && r_lc < r_n) begin
                        r_lc <= r_lc + CNT_W'(1);
                    end
                end
                ST_PUSH_WR: begin
                    r_i <= r_i + CNT_W'(1);
                    if (push_val >= ONE_FX) r_lt <= r_lt + CNT_W'(1);
                    else r_st <= r_st + CNT_W'(1);
                end
                ST_CHK: begin
                    if (r_st == '0 && r_lt == '0) begin
                        r_lc        <= '0;
                        r_ready_tbl <= 1'b1;
                    end
                end
                ST_P4: begin
                    if (pair_new >= ONE_FX) r_st <= r_st - CNT_W'(1);
                    else r_lt <= r_lt - CNT_W'(1);
                end
                ST_LL_WR: r_lt <= r_lt - CNT_W'(1);
                ST_LS_WR: r_st <= r_st - CNT_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_bin  <= i_bin;
            r_coin <= i_coin;
        end
        if (r_state == ST_P1) r_s <= s_rd;
        if (r_state == ST_P2) r_l <= s_rd;
        if (r_state == ST_P3) r_ws <= w_rd;
        if (r_state == ST_SAMP && out_free) begin
            priority if (!r_ready_tbl) begin
                r_chosen <= '0;
                r_status <= STAT_NOT_BUILT;
            end else if (CNT_W'(r_bin) >= r_n) begin
                r_chosen <= '0;
                r_status <= STAT_RANGE;
            end else begin
                r_chosen <= (WEIGHT_W'(r_coin) < t_rd[TBL_W-1:IDX_W]) ? r_bin
                                                                      : t_rd[IDX_W-1:0];
                r_status <= STAT_OK;
            end
        end
    end

    assign o_valid        = r_ov;
    assign o_chosen_index = r_chosen;
    assign o_status       = r_status;

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for alias_table_weighted_sampler_top: drives weight
// loads, table builds and samples with random idling on both sides, expects
// each result from its alias-table model or a directed row, checks each field.
// ----------------------------------------------------------------------------
module tb;
    import atws_pkg::*;

    localparam int LIMIT = 3000000;
    localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [1:0]       stat;
    } t_draw;

    typedef struct {
        logic                cmd;
        logic [WEIGHT_W-1:0] w;
        logic                last;
        logic [IDX_W-1:0]    bin;
        logic [COIN_W-1:0]   coin;
        bit                  typed;
        t_draw               draw;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CNT_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_cmd = CMD_LOAD;
    logic [WEIGHT_W-1:0]  i_weight = '0;
    logic                 i_last = 1'b0;
    logic [IDX_W-1:0]     i_bin = '0;
    logic [COIN_W-1:0]    i_coin = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [IDX_W-1:0]     o_chosen_index;
    logic [1:0]           o_status;

    alias_table_weighted_sampler_top u_top (.*);

    // predictor state
    longint unsigned  scaled [MAX_ENTRIES];
    longint unsigned  thresh [MAX_ENTRIES];
    int unsigned      alias_of [MAX_ENTRIES];
    int unsigned      small_stk [MAX_ENTRIES];
    int unsigned      large_stk [MAX_ENTRIES];
    int unsigned      small_sp, large_sp, loaded;
    bit               built;
    logic [CNT_W-1:0] count_reg;

    t_draw draws_due [$];
    int    errors = 0;
    int    cycles = 0;
    int    items = 0;
    bit    steady = 1'b0;

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("alias_table_weighted_sampler_top regression: fail");
            $finish;
        end
    end

    function automatic int unsigned eff_n();
        if (count_reg == 0) return 1;
        if (count_reg > MAX_ENTRIES) return MAX_ENTRIES;
        return count_reg;
    endfunction

    function automatic void push_bin(int unsigned i);
        if (scaled[i] >= ONE) begin
            large_stk[large_sp] = i;
            large_sp++;
        end else begin
            small_stk[small_sp] = i;
            small_sp++;
        end
    endfunction

    function automatic void build_alias_table();
        int unsigned n, s, l;
        n = eff_n();
        small_sp = 0;
        large_sp = 0;
        for (int unsigned i = 0; i < n; i++) begin
            if (i >= loaded) scaled[i] = 0;
            push_bin(i);
        end
        while (small_sp > 0 && large_sp > 0) begin
            small_sp--;
            large_sp--;
            s = small_stk[small_sp];
            l = large_stk[large_sp];
            thresh[s] = scaled[s];
            alias_of[s] = l;
            scaled[l] = scaled[l] + scaled[s] - ONE;
            push_bin(l);
        end
        while (large_sp > 0) begin
            large_sp--;
            thresh[large_stk[large_sp]] = ONE;
            alias_of[large_stk[large_sp]] = large_stk[large_sp];
        end
        while (small_sp > 0) begin
            small_sp--;
            thresh[small_stk[small_sp]] = ONE;
            alias_of[small_stk[small_sp]] = small_stk[small_sp];
        end
        loaded = 0;
        built = 1'b1;
    endfunction

    function automatic bit predict_item(t_row r, output t_draw d);
        int unsigned n;
        n = eff_n();
        d = '0;
        if (r.cmd == CMD_LOAD) begin
            if (loaded < n) begin
                scaled[loaded] = longint'(r.w) * n;
                loaded++;
            end
            if (r.last) build_alias_table();
            return 1'b0;
        end
        if (!built) d.stat = STAT_NOT_BUILT;
        else if (r.bin >= n) d.stat = STAT_RANGE;
        else begin
            d.stat = STAT_OK;
            d.idx = (r.coin < thresh[r.bin]) ? r.bin : IDX_W'(alias_of[r.bin]);
        end
        return 1'b1;
    endfunction

    function automatic int unsigned gap();
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic send(t_row r);
        int unsigned g;
        t_draw d;
        g = gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_cmd    <= r.cmd;
        i_weight <= r.w;
        i_last   <= r.last;
        i_bin    <= r.bin;
        i_coin   <= r.coin;
        do @(posedge i_clk); while (!o_ready);
        if (predict_item(r, d)) draws_due.push_back(r.typed ? r.draw : d);
        items++;
    endtask

    task automatic drain();
        while (draws_due.size() > 0) @(posedge i_clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] v);
        if (i_valid) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        drain();
        repeat (8 * eff_n() + 16) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        count_reg = v;
        loaded = 0;
        built = 1'b0;
    endtask

    function automatic t_row ld(logic [WEIGHT_W-1:0] w, logic last);
        t_row r;
        r = '{CMD_LOAD, w, last, IDX_W'($urandom), COIN_W'($urandom), 1'b0, '0};
        return r;
    endfunction

    function automatic t_row smp(logic [IDX_W-1:0] b, logic [COIN_W-1:0] c);
        t_row r;
        r = '{CMD_SAMPLE, WEIGHT_W'($urandom), 1'($urandom_range(0, 1)), b, c, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row chk(t_row r, logic [1:0] st);
        r.typed = 1'b1;
        r.draw = '{idx: '0, stat: st};
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_draw e;
        if (i_rst_n && o_valid && i_ready) begin
            if (draws_due.size() == 0) begin
                $error("unexpected result: chosen_index %0d status %0d",
                       o_chosen_index, o_status);
                errors++;
            end else begin
                e = draws_due.pop_front();
                if (o_chosen_index !== e.idx) begin
                    $error("chosen_index: expected %0d, actual %0d", e.idx, o_chosen_index);
                    errors++;
                end
                if (o_status !== e.stat) begin
                    $error("status: expected %0d, actual %0d", e.stat, o_status);
                    errors++;
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        int unsigned s;
        @(posedge i_rst_n);
        forever begin
            s = gap();
            if (s > 0) begin
                i_ready <= 1'b0;
                repeat (s) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        t_row dir [$];
        int unsigned n, k, total, mode;
        int unsigned part [MAX_ENTRIES];

        count_reg = CNT_W'(MAX_ENTRIES);
        loaded = 0;
        built = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: before any build, then a 4-entry table and a 1-entry table
        dir = '{chk(smp(10'd0, 24'd0), STAT_NOT_BUILT),
                chk(smp(10'd1023, 24'hFFFFFF), STAT_NOT_BUILT)};
        foreach (dir[i]) send(dir[i]);
        write_count(11'd4);
        dir = '{chk(smp(10'd5, 24'd0), STAT_NOT_BUILT),
                ld(25'h1FFFFFF, 1'b0), ld(25'd0, 1'b0), ld(25'h1000000, 1'b0),
                ld(25'd0, 1'b1),
                smp(10'd0, 24'd0), smp(10'd1, 24'hFFFFFF), smp(10'd1, 24'd0),
                smp(10'd3, 24'h7FFFFF), chk(smp(10'd4, 24'd0), STAT_RANGE),
                chk(smp(10'd1023, 24'hFFFFFF), STAT_RANGE),
                ld(25'h400000, 1'b0), smp(10'd2, 24'h123456),
                ld(25'h400000, 1'b1),
                smp(10'd0, 24'hFFFFFF), smp(10'd3, 24'd1),
                ld(25'h400000, 1'b0), ld(25'h400000, 1'b0), ld(25'h400000, 1'b0),
                ld(25'h400000, 1'b0), ld(25'h1FFFFFF, 1'b1),
                smp(10'd3, 24'hFFFFFF), smp(10'd2, 24'h3FFFFF)};
        foreach (dir[i]) send(dir[i]);
        write_count(11'd1);
        send(ld(25'h0AAAAAA, 1'b1));
        send(smp(10'd0, 24'hFFFFFF));
        send(chk(smp(10'd1, 24'd0), STAT_RANGE));

        // random phases
        while (items < 900) begin
            steady = ($urandom_range(0, 4) == 0);
            mode = $urandom_range(0, 19);
            if (mode == 0) write_count(CNT_W'($urandom_range(0, 1) ? 0 : 2047));
            else if (mode == 1) write_count(CNT_W'($urandom_range(1024, 2046)));
            else if (mode < 6) write_count(CNT_W'($urandom_range(1, 64)));
            else if (mode < 12) write_count(CNT_W'($urandom_range(1, 12)));
            if ($urandom_range(0, 3) == 0) send(smp(IDX_W'($urandom), COIN_W'($urandom)));
            n = eff_n();
            repeat ($urandom_range(1, 3)) begin
                k = (n > 64) ? $urandom_range(1, 40) : n;
                mode = $urandom_range(0, 9);
                if (mode == 0 && k > 1) k = $urandom_range(1, k - 1);
                else if (mode == 1) k = k + $urandom_range(1, 3);
                total = 0;
                for (int unsigned i = 0; i < k && i < MAX_ENTRIES; i++) begin
                    part[i] = $urandom_range(0, 1000);
                    total += part[i];
                end
                if (total == 0) total = 1;
                for (int unsigned i = 0; i < k && i < MAX_ENTRIES; i++) begin
                    if (mode == 2)
                        send(ld(WEIGHT_W'($urandom), i == k - 1));
                    else
                        send(ld(WEIGHT_W'((longint'(part[i]) * ONE) / (total * (n > 64
                             ? 1 : 1))), i == k - 1));
                end
                repeat ($urandom_range(3, 12)) begin
                    if ($urandom_range(0, 9) == 0)
                        send(smp(IDX_W'($urandom), COIN_W'($urandom)));
                    else
                        send(smp(IDX_W'($urandom_range(0, n - 1)), COIN_W'($urandom)));
                end
                if ($urandom_range(0, 7) == 0) begin
                    if (i_valid) begin
                        i_valid <= 1'b0;
                        @(posedge i_clk);
                    end
                    drain();
                end
            end
        end

        i_valid <= 1'b0;
        drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && draws_due.size() == 0) begin
            $display("alias_table_weighted_sampler_top regression: pass");
        end else begin
            $display("alias_table_weighted_sampler_top regression: fail");
        end
        $finish;
    end

endmodule

@@ alias_table_weighted_sampler_top.f @@
design/atws_pkg.sv
design/atws_ram.sv
design/alias_table_weighted_sampler_top.sv
tb/sv/tb.sv
